>>> hdl/seu_pkg.sv
// ----------------------------------------------------------------------------
// seu_pkg: shared constants and types for the solar direction pipeline
// Holds the CORDIC arctangent table and the shared widths.
// ----------------------------------------------------------------------------
package seu_pkg;

  localparam int CordicStages = 32;
  localparam int CordicUsed   = (CordicStages > 40) ? 40 : CordicStages;
  localparam int TimeW        = 25;
  localparam int CfgIdxW      = 3;
  localparam int SideW        = 32;

  localparam logic [CfgIdxW-1:0] REG_MEAN_LON  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LON_RATE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ANOM_AMP  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ANOM_RATE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ANOM_PH   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COS_OBL   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SIN_OBL   = 3'd6;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30     = 34'sd1073741824;

  function automatic logic signed [33:0] atan_rev(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;        25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;         28: r = 34'sd3;         29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
  } cordic_t;

endpackage

>>> hdl/seu_cordic.sv
// ----------------------------------------------------------------------------
// seu_cordic: pipelined rotation CORDIC with a sideband that travels along
// One stage per register; quadrant folding and clamping in the last stage.
// ----------------------------------------------------------------------------
module seu_cordic
  import seu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [31:0]              in_angle,
  input  logic [SideW-1:0]         in_side,
  output logic                     out_valid,
  output logic signed [31:0]       out_cos,
  output logic signed [31:0]       out_sin,
  output logic [SideW-1:0]         out_side
);

  cordic_t          st_r   [CordicUsed+1];
  logic             vld_r  [CordicUsed+1];
  logic [SideW-1:0] side_r [CordicUsed+1];
  logic signed [33:0] cx, cy;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_valid;
    st_r[0].x    <= CordicGain;
    st_r[0].y    <= '0;
    st_r[0].z    <= {4'b0, in_angle[29:0]};
    st_r[0].quad <= in_angle[31:30];
    side_r[0]    <= in_side;
  end

  for (genvar i = 0; i < CordicUsed; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
      side_r[i+1]    <= side_r[i];
      st_r[i+1].quad <= st_r[i].quad;
      if (!st_r[i].z[33]) begin
        st_r[i+1].x <= st_r[i].x - (st_r[i].y >>> i);
        st_r[i+1].y <= st_r[i].y + (st_r[i].x >>> i);
        st_r[i+1].z <= st_r[i].z - atan_rev(i);
      end else begin
        st_r[i+1].x <= st_r[i].x + (st_r[i].y >>> i);
        st_r[i+1].y <= st_r[i].y - (st_r[i].x >>> i);
        st_r[i+1].z <= st_r[i].z + atan_rev(i);
      end
    end
  end

  always_comb begin
    cx = st_r[CordicUsed].x;
    cy = st_r[CordicUsed].y;
    if (cx > OneQ30) cx = OneQ30;
    if (cx < -OneQ30) cx = -OneQ30;
    if (cy > OneQ30) cy = OneQ30;
    if (cy < -OneQ30) cy = -OneQ30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= vld_r[CordicUsed];
    out_side <= side_r[CordicUsed];
    case (st_r[CordicUsed].quad)
      2'd0: begin out_cos <= cx[31:0];      out_sin <= cy[31:0];      end
      2'd1: begin out_cos <= -cy[31:0];     out_sin <= cx[31:0];      end
      2'd2: begin out_cos <= -cx[31:0];     out_sin <= -cy[31:0];     end
      default: begin out_cos <= cy[31:0];   out_sin <= -cx[31:0];     end
    endcase
  end

endmodule

>>> hdl/seu_norm.sv
// ----------------------------------------------------------------------------
// seu_norm: vector normalisation pipeline
// Squares and sums, a one-bit-per-stage square root, then three
// restoring dividers, one quotient bit per stage.
// ----------------------------------------------------------------------------
module seu_norm
  import seu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [31:0] in_x,
  input  logic signed [32:0] in_y,
  input  logic signed [32:0] in_z,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  localparam int SqN = 32;
  localparam int QN  = 32;

  logic [31:0] ax_r, ay_r, az_r;
  logic [2:0]  sg_r;
  logic        v0_r;
  logic [63:0] px_r, py_r, pz_r;
  logic [31:0] ax1_r, ay1_r, az1_r;
  logic [2:0]  sg1_r;
  logic        v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
    ax_r <= in_x[31] ? 32'(-in_x) : in_x[31:0];
    ay_r <= in_y[32] ? 32'(-in_y) : in_y[31:0];
    az_r <= in_z[32] ? 32'(-in_z) : in_z[31:0];
    sg_r <= {in_z[32], in_y[32], in_x[31]};
    px_r <= ax_r * ax_r;
    py_r <= ay_r * ay_r;
    pz_r <= az_r * az_r;
    ax1_r <= ax_r;  ay1_r <= ay_r;  az1_r <= az_r;  sg1_r <= sg_r;
  end

  // square root: remainder, root, remaining radicand
  logic [65:0] rem_r  [SqN+1];
  logic [32:0] root_r [SqN+1];
  logic [63:0] rad_r  [SqN+1];
  logic [31:0] sx_r [SqN+1], sy_r [SqN+1], sz_r [SqN+1];
  logic [2:0]  ss_r [SqN+1];
  logic        sv_r [SqN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else        sv_r[0] <= v1_r;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    rad_r[0]  <= px_r + py_r + pz_r;
    sx_r[0] <= ax1_r;  sy_r[0] <= ay1_r;  sz_r[0] <= az1_r;  ss_r[0] <= sg1_r;
  end

  for (genvar i = 0; i < SqN; i++) begin : g_sq
    logic [65:0] trial, cur;
    assign cur   = {rem_r[i][63:0], rad_r[i][63:62]};
    assign trial = {root_r[i], 2'b01} ;
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[i+1] <= 1'b0;
      else        sv_r[i+1] <= sv_r[i];
      rad_r[i+1] <= {rad_r[i][61:0], 2'b00};
      if (cur >= {31'b0, trial[34:0]}) begin
        rem_r[i+1]  <= cur - {31'b0, trial[34:0]};
        root_r[i+1] <= {root_r[i][31:0], 1'b1};
      end else begin
        rem_r[i+1]  <= cur;
        root_r[i+1] <= {root_r[i][31:0], 1'b0};
      end
      sx_r[i+1] <= sx_r[i];  sy_r[i+1] <= sy_r[i];  sz_r[i+1] <= sz_r[i];
      ss_r[i+1] <= ss_r[i];
    end
  end

  // division: numerator |c|*2^30, 62 bits; quotient at most 2^30 so 32 bits
  // suffice once the upper numerator bits are preloaded (m >= |c|).
  logic [31:0] m_r   [QN+1];
  logic [31:0] rx_r  [QN+1], ry_r [QN+1], rz_r [QN+1];
  logic [31:0] nx_r  [QN+1], ny_r [QN+1], nz_r [QN+1];
  logic [31:0] qx_r  [QN+1], qy_r [QN+1], qz_r [QN+1];
  logic [2:0]  ds_r  [QN+1];
  logic        dv_r  [QN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= sv_r[SqN];
    m_r[0]  <= root_r[SqN][31:0];
    rx_r[0] <= {2'b0, sx_r[SqN][31:2]};
    ry_r[0] <= {2'b0, sy_r[SqN][31:2]};
    rz_r[0] <= {2'b0, sz_r[SqN][31:2]};
    nx_r[0] <= {sx_r[SqN][1:0], 30'b0};
    ny_r[0] <= {sy_r[SqN][1:0], 30'b0};
    nz_r[0] <= {sz_r[SqN][1:0], 30'b0};
    qx_r[0] <= '0;  qy_r[0] <= '0;  qz_r[0] <= '0;
    ds_r[0] <= ss_r[SqN];
  end

  for (genvar i = 0; i < QN; i++) begin : g_div
    logic [32:0] cx, cy, cz;
    assign cx = {rx_r[i], nx_r[i][31]};
    assign cy = {ry_r[i], ny_r[i][31]};
    assign cz = {rz_r[i], nz_r[i][31]};
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[i+1] <= 1'b0;
      else        dv_r[i+1] <= dv_r[i];
      m_r[i+1]  <= m_r[i];
      ds_r[i+1] <= ds_r[i];
      nx_r[i+1] <= {nx_r[i][30:0], 1'b0};
      ny_r[i+1] <= {ny_r[i][30:0], 1'b0};
      nz_r[i+1] <= {nz_r[i][30:0], 1'b0};
      if (cx >= {1'b0, m_r[i]}) begin
        rx_r[i+1] <= 32'(cx - {1'b0, m_r[i]});  qx_r[i+1] <= {qx_r[i][30:0], 1'b1};
      end else begin
        rx_r[i+1] <= cx[31:0];  qx_r[i+1] <= {qx_r[i][30:0], 1'b0};
      end
      if (cy >= {1'b0, m_r[i]}) begin
        ry_r[i+1] <= 32'(cy - {1'b0, m_r[i]});  qy_r[i+1] <= {qy_r[i][30:0], 1'b1};
      end else begin
        ry_r[i+1] <= cy[31:0];  qy_r[i+1] <= {qy_r[i][30:0], 1'b0};
      end
      if (cz >= {1'b0, m_r[i]}) begin
        rz_r[i+1] <= 32'(cz - {1'b0, m_r[i]});  qz_r[i+1] <= {qz_r[i][30:0], 1'b1};
      end else begin
        rz_r[i+1] <= cz[31:0];  qz_r[i+1] <= {qz_r[i][30:0], 1'b0};
      end
    end
  end

  logic zero;
  assign zero = (m_r[QN] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= dv_r[QN];
    out_x <= zero ? '0 : (ds_r[QN][0] ? -qx_r[QN] : qx_r[QN]);
    out_y <= zero ? '0 : (ds_r[QN][1] ? -qy_r[QN] : qy_r[QN]);
    out_z <= zero ? '0 : (ds_r[QN][2] ? -qz_r[QN] : qz_r[QN]);
  end

endmodule

>>> hdl/solar_ephemeris_unit_vector.sv
// ----------------------------------------------------------------------------
// solar_ephemeris_unit_vector: Sun direction unit vector from time
// Two CORDIC passes for anomaly and longitude, then normalisation.
// ----------------------------------------------------------------------------
// The path from the accepting edge to out_valid runs through the two CORDIC
// chains, the root chain and the quotient chains; one request is taken per
// cycle and busy never rises.
// Results appear with out_valid for one cycle; the receiver cannot stall.
// Reset clears all valid bits and loads the register defaults.
module solar_ephemeris_unit_vector
  import seu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [TimeW-1:0]   in_time_days,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_dir_x,
  output logic signed [31:0] out_dir_y,
  output logic signed [31:0] out_dir_z
);

  logic [31:0] mlon_r, lrate_r, amp_r, arate_r, aph_r, cobl_r, sobl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mlon_r <= '0; lrate_r <= '0; amp_r <= '0; arate_r <= '0; aph_r <= '0;
      cobl_r <= 32'h4000_0000; sobl_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEAN_LON:  mlon_r  <= cfg_wdata;
        REG_LON_RATE:  lrate_r <= cfg_wdata;
        REG_ANOM_AMP:  amp_r   <= cfg_wdata;
        REG_ANOM_RATE: arate_r <= cfg_wdata;
        REG_ANOM_PH:   aph_r   <= cfg_wdata;
        REG_COS_OBL:   cobl_r  <= cfg_wdata;
        REG_SIN_OBL:   sobl_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic        v1_r, v2_r;
  logic [56:0] plin_r, pph_r;
  logic [31:0] lin_r, ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0;
    end else begin
      v1_r <= start; v2_r <= v1_r;
    end
    plin_r <= lrate_r * in_time_days;
    pph_r  <= arate_r * in_time_days;
    lin_r  <= mlon_r + plin_r[47:16];
    ph_r   <= aph_r + pph_r[47:16];
  end

  logic               a_v;
  logic signed [31:0] a_c, a_s;
  logic [SideW-1:0]   a_lin;

  seu_cordic u_anom (
    .clk(clk), .rst_n(rst_n), .in_valid(v2_r), .in_angle(ph_r), .in_side(lin_r),
    .out_valid(a_v), .out_cos(a_c), .out_sin(a_s), .out_side(a_lin)
  );

  logic        v3_r, v4_r;
  logic [63:0] corr_r;
  logic [31:0] lin3_r, los_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      v3_r <= a_v; v4_r <= v3_r;
    end
    corr_r <= $signed(amp_r) * a_s;
    lin3_r <= a_lin;
    los_r  <= lin3_r - corr_r[61:30];
  end

  logic               l_v;
  logic signed [31:0] l_c, l_s;
  logic [SideW-1:0]   l_side;

  seu_cordic u_lon (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .in_angle(los_r), .in_side('0),
    .out_valid(l_v), .out_cos(l_c), .out_sin(l_s), .out_side(l_side)
  );

  logic               v5_r;
  logic signed [63:0] py_r, pz_r;
  logic signed [31:0] vx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= l_v & ~|l_side;
    py_r <= $signed(cobl_r) * l_s;
    pz_r <= $signed(sobl_r) * l_s;
    vx_r <= l_c;
  end

  seu_norm u_norm (
    .clk(clk), .rst_n(rst_n), .in_valid(v5_r),
    .in_x(vx_r), .in_y(py_r[62:30]), .in_z(pz_r[62:30]),
    .out_valid(out_valid), .out_x(out_dir_x), .out_y(out_dir_y), .out_z(out_dir_z)
  );

endmodule

>>> hdl/seu_checker.sv
// ----------------------------------------------------------------------------
// seu_checker: port-level checks for the solar direction pipeline
// Bound to the top level.
// ----------------------------------------------------------------------------
module seu_checker
  import seu_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_dir_x,
  input logic signed [31:0] out_dir_y,
  input logic signed [31:0] out_dir_z
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x <= 32'sd1073741824 && out_dir_x >= -32'sd1073741824))
    else $error("x out of range");
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_y <= 32'sd1073741824 && out_dir_y >= -32'sd1073741824))
    else $error("y out of range");

endmodule

bind solar_ephemeris_unit_vector seu_checker u_seu_checker (.*);

>>> dv/solar_ephemeris_unit_vector_test.sv
// ----------------------------------------------------------------------------
// solar_ephemeris_unit_vector_test: self-checking bench for the Sun direction
// Drives time requests through several register settings, predicts each unit
// vector in the bench and checks every result strobe against the prediction.
// ----------------------------------------------------------------------------
class sun_dir_board;
  logic signed [31:0] exp_x[$];
  logic signed [31:0] exp_y[$];
  logic signed [31:0] exp_z[$];
  int unsigned        errors;

  function void note_request(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    exp_x.push_back(x);
    exp_y.push_back(y);
    exp_z.push_back(z);
  endfunction

  function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    logic signed [31:0] ex, ey, ez;
    if (exp_x.size() == 0) begin
      $error("unexpected result %0d %0d %0d", x, y, z);
      errors++;
      return;
    end
    ex = exp_x.pop_front();
    ey = exp_y.pop_front();
    ez = exp_z.pop_front();
    if (x !== ex) begin
      $error("dir_x expected %0d actual %0d", ex, x);
      errors++;
    end
    if (y !== ey) begin
      $error("dir_y expected %0d actual %0d", ey, y);
      errors++;
    end
    if (z !== ez) begin
      $error("dir_z expected %0d actual %0d", ez, z);
      errors++;
    end
  endfunction

  function int pending();
    return exp_x.size();
  endfunction
endclass

module solar_ephemeris_unit_vector_test;
  import seu_pkg::*;

  localparam int Latency = 2 * CordicStages + 77;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [TimeW-1:0]   in_time_days = '0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               out_valid;
  logic signed [31:0] out_dir_x;
  logic signed [31:0] out_dir_y;
  logic signed [31:0] out_dir_z;

  logic [31:0] mean_lon, lon_rate, anom_amp, anom_rate, anom_ph, cos_obl, sin_obl;
  int          idle_pct;
  sun_dir_board board;

  solar_ephemeris_unit_vector u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_time_days(in_time_days), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .out_valid(out_valid), .out_dir_x(out_dir_x),
    .out_dir_y(out_dir_y), .out_dir_z(out_dir_z)
  );

  always #10 clk = ~clk;

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic longint floor_sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic signed [33:0] a;
    x = 652032874;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < CordicUsed; i++) begin
      a = atan_rev(i);
      dx = floor_sra(y, i);
      dy = floor_sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(a);
      end else begin
        x += dx; y -= dy; z += longint'(a);
      end
    end
    if (x > 64'sd1073741824) x = 1073741824;
    if (x < -64'sd1073741824) x = -1073741824;
    if (y > 64'sd1073741824) y = 1073741824;
    if (y < -64'sd1073741824) y = -1073741824;
    case (ang[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] scale_comp(longint v, logic [63:0] m);
    logic [63:0] mag, q;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q = (mag << 30) / m;
    return (v < 0) ? -q[31:0] : q[31:0];
  endfunction

  function automatic void predict_direction(logic [TimeW-1:0] t,
      output logic signed [31:0] ox, output logic signed [31:0] oy,
      output logic signed [31:0] oz);
    logic [63:0] prod, n2, m;
    logic [31:0] lin, ph, lon;
    longint ca, sa, cl, sl, corr, vx, vy, vz;
    prod = 64'(lon_rate) * 64'(t);
    lin = prod[47:16];
    prod = 64'(anom_rate) * 64'(t);
    ph = anom_ph + prod[47:16];
    rotate(ph, ca, sa);
    corr = floor_sra(longint'($signed(anom_amp)) * sa, 30);
    lon = mean_lon + lin - corr[31:0];
    rotate(lon, cl, sl);
    vx = cl;
    vy = floor_sra(longint'($signed(cos_obl)) * sl, 30);
    vz = floor_sra(longint'($signed(sin_obl)) * sl, 30);
    n2 = 64'(vx * vx) + 64'(vy * vy) + 64'(vz * vz);
    m = int_root(n2);
    if (m == 0) begin
      ox = 0; oy = 0; oz = 0;
    end else begin
      ox = scale_comp(vx, m);
      oy = scale_comp(vy, m);
      oz = scale_comp(vz, m);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_dir_x, out_dir_y, out_dir_z);
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MEAN_LON:  mean_lon = val;
      REG_LON_RATE:  lon_rate = val;
      REG_ANOM_AMP:  anom_amp = val;
      REG_ANOM_RATE: anom_rate = val;
      REG_ANOM_PH:   anom_ph = val;
      REG_COS_OBL:   cos_obl = val;
      default:       sin_obl = val;
    endcase
  endtask

  task automatic send_request(logic [TimeW-1:0] t);
    logic signed [31:0] ex, ey, ez;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_time_days <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_direction(t, ex, ey, ez);
    board.note_request(ex, ey, ez);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
  endtask

  task automatic program_all(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
      logic [31:0] v3, logic [31:0] v4, logic [31:0] v5, logic [31:0] v6);
    write_reg(REG_MEAN_LON, v0);
    write_reg(REG_LON_RATE, v1);
    write_reg(REG_ANOM_AMP, v2);
    write_reg(REG_ANOM_RATE, v3);
    write_reg(REG_ANOM_PH, v4);
    write_reg(REG_COS_OBL, v5);
    write_reg(REG_SIN_OBL, v6);
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    case ($urandom_range(3))
      0: return TimeW'($urandom_range(255));
      1: return {TimeW{1'b1}} - TimeW'($urandom_range(255));
      default: return TimeW'($urandom);
    endcase
  endfunction

  initial begin
    board = new();
    mean_lon = 0; lon_rate = 0; anom_amp = 0; anom_rate = 0; anom_ph = 0;
    cos_obl = 32'h4000_0000; sin_obl = 0;
    idle_pct = 17;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults first, at time zero and at the largest time.
    send_request('0);
    send_request({TimeW{1'b1}});
    drain();
    program_all(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff,
                32'hffff_ffff, 32'hc000_0000, 32'h4000_0000);
    for (int i = 0; i < 8; i++) send_request(TimeW'(1) << (3 * i));
    send_request({TimeW{1'b1}});
    drain();
    program_all(32'h4000_0000, 0, 32'h7fff_ffff, 0, 32'h4000_0000, 0, 0);
    for (int q = 0; q < 4; q++) begin
      write_reg(REG_MEAN_LON, 32'(q) << 30);
      send_request('0);
      drain();
    end
    // A full-range out-of-range obliquity pair.
    program_all(32'h1234_5678, 32'h00b2_1234, 32'h0050_0000, 32'h00b0_0000,
                32'h0, 32'hffff_ffff, 32'h7fff_ffff);
    for (int i = 0; i < 6; i++) send_request(rand_time());
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 71 : 0;
      for (int k = 0; k < 5; k++) begin
        if ($urandom_range(3) == 0)
          program_all($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        else
          program_all($urandom, $urandom_range(32'h00ff_ffff),
                      $signed(32'($urandom_range(32'h00ff_ffff))) - 32'sh0080_0000,
                      $urandom_range(32'h00ff_ffff), $urandom,
                      32'($urandom_range(32'h7fff_ffff)) - 32'h4000_0000,
                      32'($urandom_range(32'h7fff_ffff)) - 32'h4000_0000);
        for (int n = 0; n < 48; n++) send_request(rand_time());
        drain();
      end
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/seu_pkg.sv
hdl/seu_cordic.sv
hdl/seu_norm.sv
hdl/solar_ephemeris_unit_vector.sv
hdl/seu_checker.sv
dv/solar_ephemeris_unit_vector_test.sv
